// File: rtl/ffra_pkg.sv
// Shared types and constants of the frame-fenced ring allocator.
// Used by the arithmetic unit and the top level; depends on nothing else.
package ffra_pkg;

  localparam int unsigned OFFSET_BITS = 24;
  localparam int unsigned CNT_W       = 25;
  localparam int unsigned SIZE_W      = 25;
  localparam int unsigned ALIGN_W     = 13;
  localparam int unsigned FRAME_W     = 64;
  localparam int unsigned RET_W       = 7;
  localparam int unsigned ALU_W       = 27;
  localparam int unsigned IN_DATA_W   = 104;
  localparam int unsigned OUT_DATA_W  = 152;

  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [CNT_W-1:0] CAP_LIMIT = CNT_W'(64'd1 << OFFSET_BITS);

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_RETIRE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CHK   = 8'b0000_0010,
    ST_ALIGN = 8'b0000_0100,
    ST_FIT   = 8'b0000_1000,
    ST_USED  = 8'b0001_0000,
    ST_ACC   = 8'b0010_0000,
    ST_RET   = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic [FRAME_W-1:0]     frame;
    logic [CNT_W-1:0]       consumed;
    logic [OFFSET_BITS-1:0] start;
  } range_t;

  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

endpackage

// File: rtl/ffra_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module ffra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ffra_alu.sv
// Shared add and subtract unit of the allocator sequencer.
// Depends on ffra_pkg.
module ffra_alu
  import ffra_pkg::*;
(
  input  alu_req_t         req_i,
  output logic [ALU_W-1:0] sum_o
);

  logic [ALU_W-1:0] b_op;

  assign b_op  = req_i.sub ? ~req_i.b : req_i.b;
  assign sum_o = req_i.a + b_op + ALU_W'(req_i.sub);

endmodule

// File: rtl/frame_fenced_ring_allocator_top.sv
// Top level of the frame-fenced ring allocator: sequencer, counters and range FIFO.
// Depends on ffra_pkg, ffra_ram and ffra_alu.
//
// One input item is taken on the s_axis channel when tvalid and tready are both
// high; tuser carries the operation (begin frame, allocate, retire). Each item
// gives exactly one result item on the m_axis channel. The block works on one
// item at a time and is not ready while it does.
// A begin item or an unused operation goes from idle straight to the finish state.
// An allocate item steps through the check, align, fit, used and accumulate states;
// it ends at the check when refused there, and at the fit state when no gap fits,
// after a second align and fit on the wrap to offset 0 where one is tried. The align,
// fit, used and accumulate steps go through the one shared adder. A retire item
// releases ranges in turn, since the range FIFO memory is read one entry per cycle.
// The result waits in an output register; the next item is taken while it waits,
// and the following result is held back until the receiver takes the first.
// Reset clears the FIFO, the head, the byte counters and the current frame, and sets
// the capacity register to 2^24. The capacity is written through cfg_we_i and
// cfg_wdata_i; the user must write it only while no item is in flight (not enforced).
module frame_fenced_ring_allocator_top
  import ffra_pkg::*;
#(
  parameter int unsigned MAX_RANGES = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CNT_W-1:0]      cfg_wdata_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // Fields from bit 0: size_bytes(25), alignment(13), frame_number(64), zero pad.
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // Fields from bit 0: op(2).
  input  logic [1:0]            s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // Fields from bit 0: offset(24), alloc_frame(64), retired_count(7),
  // used_bytes(25), peak_bytes(25), zero pad.
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // Fields from bit 0: ok(1).
  output logic [0:0]            m_axis_tuser_o
);

  localparam int unsigned PW = $clog2(MAX_RANGES);
  localparam int unsigned CW = $clog2(MAX_RANGES + 1);
  localparam int unsigned ALIGN_LSB = SIZE_W;
  localparam int unsigned FRAME_LSB = SIZE_W + ALIGN_W;
  localparam int unsigned OUT_USED  = OFFSET_BITS + FRAME_W + RET_W;
  localparam int unsigned OUT_PAD   = OUT_DATA_W - OUT_USED - 2 * CNT_W;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(MAX_RANGES - 1)) ? '0 : p + 1'b1;
  endfunction

  state_e st_q, st_d;

  logic [CNT_W-1:0]       cfg_q;
  logic [PW-1:0]          rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d, raddr;
  logic [CW-1:0]          count_q, count_d;
  logic [OFFSET_BITS-1:0] head_q, head_d;
  logic [CNT_W-1:0]       used_q, used_d, peak_q, peak_d;
  logic [FRAME_W-1:0]     cur_frame_q, cur_frame_d;

  logic [SIZE_W-1:0]      size_q, size_d;
  logic [ALIGN_W-1:0]     align_q, align_d;
  logic [FRAME_W-1:0]     frame_q, frame_d;

  logic [OFFSET_BITS-1:0] lo_q, lo_d, tail_q, tail_d;
  logic [CNT_W-1:0]       hi_q, hi_d, grant_q, grant_d;
  logic [ALU_W-1:0]       aligned_q, aligned_d, endp_q, endp_d;
  logic                   second_q, second_d;

  logic                   res_ok_q, res_ok_d;
  logic [OFFSET_BITS-1:0] res_off_q, res_off_d;
  logic [FRAME_W-1:0]     res_frame_q, res_frame_d;
  logic [RET_W-1:0]       res_ret_q, res_ret_d;

  logic                   out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0]  out_data_q, out_data_d;
  logic                   out_ok_q, out_ok_d;

  logic                   s_acc, m_acc, we, good, fit, pop, pow2, out_free;
  range_t                 rd_entry, wr_entry;
  logic [ALIGN_W-1:0]     align_m1;
  logic [CNT_W-1:0]       cap;
  alu_req_t               alu_req;
  logic [ALU_W-1:0]       alu_sum;

  ffra_ram #(
    .WIDTH($bits(range_t)),
    .DEPTH(MAX_RANGES)
  ) u_ranges (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wr_ptr_q),
    .wdata_i(wr_entry),
    .raddr_i(raddr),
    .rdata_o(rd_entry)
  );

  ffra_alu u_alu (
    .req_i(alu_req),
    .sum_o(alu_sum)
  );

  assign s_axis_tready_o = (st_q == ST_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign m_acc           = out_valid_q && m_axis_tready_i;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_ok_q;

  assign cap      = (cfg_q > CAP_LIMIT) ? CAP_LIMIT : cfg_q;
  assign align_m1 = align_q - 1'b1;
  assign pow2     = (align_q != '0) && ((align_q & align_m1) == '0);
  assign good     = (size_q != '0) && (size_q <= cap) && pow2 &&
                    (count_q < CW'(MAX_RANGES)) &&
                    !((count_q != '0) && (head_q == rd_entry.start));
  assign fit      = (aligned_q <= ALU_W'(hi_q)) && (alu_sum <= ALU_W'(hi_q));
  assign pop      = (st_q == ST_RET) && (count_q != '0) && (rd_entry.frame <= frame_q);
  assign raddr    = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;

  assign wr_entry.frame    = cur_frame_q;
  assign wr_entry.consumed = grant_q;
  assign wr_entry.start    = aligned_q[OFFSET_BITS-1:0];

  always_comb begin
    alu_req = '0;
    unique case (st_q)
      ST_ALIGN: begin
        alu_req.a = ALU_W'(lo_q);
        alu_req.b = ALU_W'(align_m1);
      end
      ST_FIT: begin
        alu_req.a = aligned_q;
        alu_req.b = ALU_W'(size_q);
      end
      ST_USED: begin
        alu_req.sub = 1'b1;
        alu_req.a   = endp_q;
        alu_req.b   = ALU_W'(lo_q);
      end
      ST_ACC: begin
        alu_req.a = ALU_W'(used_q);
        alu_req.b = ALU_W'(grant_q);
      end
      ST_RET: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(used_q);
        alu_req.b   = ALU_W'(rd_entry.consumed);
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  always_comb begin
    st_d        = st_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    count_d     = count_q;
    head_d      = head_q;
    used_d      = used_q;
    peak_d      = peak_q;
    cur_frame_d = cur_frame_q;
    size_d      = size_q;
    align_d     = align_q;
    frame_d     = frame_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    tail_d      = tail_q;
    grant_d     = grant_q;
    aligned_d   = aligned_q;
    endp_d      = endp_q;
    second_d    = second_q;
    res_ok_d    = res_ok_q;
    res_off_d   = res_off_q;
    res_frame_d = res_frame_q;
    res_ret_d   = res_ret_q;
    out_valid_d = m_acc ? 1'b0 : out_valid_q;
    out_data_d  = out_data_q;
    out_ok_d    = out_ok_q;
    we          = 1'b0;

    unique case (st_q)
      ST_IDLE: begin
        if (s_acc) begin
          size_d      = s_axis_tdata_i[SIZE_W-1:0];
          align_d     = s_axis_tdata_i[ALIGN_LSB +: ALIGN_W];
          frame_d     = s_axis_tdata_i[FRAME_LSB +: FRAME_W];
          res_ok_d    = 1'b0;
          res_off_d   = '0;
          res_frame_d = '0;
          res_ret_d   = '0;
          unique case (op_e'(s_axis_tuser_i))
            OP_BEGIN: begin
              cur_frame_d = s_axis_tdata_i[FRAME_LSB +: FRAME_W];
              res_ok_d    = 1'b1;
              st_d        = ST_FIN;
            end
            OP_ALLOC: begin
              st_d = ST_CHK;
            end
            OP_RETIRE: begin
              res_ok_d = 1'b1;
              st_d     = ST_RET;
            end
            OP_NONE: begin
              st_d = ST_FIN;
            end
            default: begin
              st_d = ST_FIN;
            end
          endcase
        end
      end
      ST_CHK: begin
        tail_d   = rd_entry.start;
        second_d = 1'b0;
        if (!good) begin
          st_d = ST_FIN;
        end else begin
          st_d = ST_ALIGN;
          if (count_q == '0) begin
            lo_d = '0;
            hi_d = cap;
          end else if (head_q < rd_entry.start) begin
            lo_d = head_q;
            hi_d = CNT_W'(rd_entry.start);
          end else begin
            lo_d     = head_q;
            hi_d     = cap;
            second_d = (rd_entry.start != '0);
          end
        end
      end
      ST_ALIGN: begin
        aligned_d = alu_sum & ~ALU_W'(align_m1);
        st_d      = ST_FIT;
      end
      ST_FIT: begin
        endp_d = alu_sum;
        if (fit) begin
          st_d = ST_USED;
        end else if (second_q) begin
          lo_d     = '0;
          hi_d     = CNT_W'(tail_q);
          second_d = 1'b0;
          st_d     = ST_ALIGN;
        end else begin
          st_d = ST_FIN;
        end
      end
      ST_USED: begin
        grant_d = alu_sum[CNT_W-1:0];
        st_d    = ST_ACC;
      end
      ST_ACC: begin
        used_d      = (alu_sum > ALU_W'(CNT_MAX)) ? CNT_MAX : alu_sum[CNT_W-1:0];
        peak_d      = (used_d > peak_q) ? used_d : peak_q;
        we          = 1'b1;
        wr_ptr_d    = ptr_inc(wr_ptr_q);
        count_d     = count_q + 1'b1;
        head_d      = (endp_q == ALU_W'(cap)) ? '0 : endp_q[OFFSET_BITS-1:0];
        res_ok_d    = 1'b1;
        res_off_d   = aligned_q[OFFSET_BITS-1:0];
        res_frame_d = cur_frame_q;
        st_d        = ST_FIN;
      end
      ST_RET: begin
        if (pop) begin
          used_d    = alu_sum[ALU_W-1] ? '0 : alu_sum[CNT_W-1:0];
          rd_ptr_d  = ptr_inc(rd_ptr_q);
          count_d   = count_q - 1'b1;
          res_ret_d = res_ret_q + 1'b1;
        end else begin
          if (count_q == '0) begin
            head_d = '0;
            used_d = '0;
          end
          st_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ok_d    = res_ok_q;
          out_data_d  = {{OUT_PAD{1'b0}}, peak_q, used_q, res_ret_q, res_frame_q, res_off_q};
          st_d        = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      cfg_q       <= CAP_LIMIT;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      count_q     <= '0;
      head_q      <= '0;
      used_q      <= '0;
      peak_q      <= '0;
      cur_frame_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cfg_q       <= cfg_we_i ? cfg_wdata_i : cfg_q;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      count_q     <= count_d;
      head_q      <= head_d;
      used_q      <= used_d;
      peak_q      <= peak_d;
      cur_frame_q <= cur_frame_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q      <= size_d;
    align_q     <= align_d;
    frame_q     <= frame_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    tail_q      <= tail_d;
    grant_q     <= grant_d;
    aligned_q   <= aligned_d;
    endp_q      <= endp_d;
    second_q    <= second_d;
    res_ok_q    <= res_ok_d;
    res_off_q   <= res_off_d;
    res_frame_q <= res_frame_d;
    res_ret_q   <= res_ret_d;
    out_data_q  <= out_data_d;
    out_ok_q    <= out_ok_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_RANGES))
    else $error("range FIFO count exceeds its depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 && st_q != ST_RET) |-> (head_q == '0))
    else $error("empty ring with a nonzero head");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= peak_q)
    else $error("used byte count above the peak");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FIN && out_free) |=> (m_axis_tvalid_o && st_q == ST_IDLE))
    else $error("finished item did not reach the output register");

endmodule
